FILE: design/sitoa_pkg.sv
// shared constants for the signed integer to decimal text block
`timescale 1ns / 1ps

package sitoa_pkg;

    // width of the signed input value
    localparam int VALUE_BITS = 32;

    // input payload rounded up to whole bytes
    localparam int S_DATA_W = ((VALUE_BITS + 7) / 8) * 8;

    // magnitude bits converted by each pipeline stage
    localparam int STEP_BITS = 4;
    localparam int STAGE_N   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS  = STAGE_N * STEP_BITS;

    // decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
    localparam int DIG_N = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int DIG_W = $clog2(DIG_N);
    localparam int BCD_W = DIG_N * 4;

    // ascii codes
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

endpackage

FILE: design/signed_int_to_decimal_ascii_top.sv
// signed integer to decimal ascii text converter, pipelined double dabble and serializer
`timescale 1ns / 1ps
//
// Usage:
//   s_* channel: one signed value per item in s_tdata, accepted when s_tvalid and
//   s_tready are both high. m_* channel: the decimal text of each value, one ascii
//   character per item in m_tdata, most significant first, a leading '-' for
//   negative values, no leading zeros, '0' for zero; m_tlast marks the final
//   character. The most negative value prints correctly.
//   The first character comes out once its value has passed the conversion stage
//   registers, the leading digit stage and the serializer.
//   Throughput: a new value can enter the binary-to-BCD pipeline every cycle unless
//   the pipeline is stalled behind the serializer; the serializer emits one character
//   per cycle while m_tready is high, so a value occupies the output for its digit
//   count plus one character for a minus sign. The serializer sets the sustained rate.
//   Reset (aresetn low, synchronous) empties the pipeline and the serializer.
//   When the receiver stalls, the current character holds, the pipeline stops as
//   a whole once its final stage is full and s_tready falls; nothing is lost.
//
module signed_int_to_decimal_ascii_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sitoa_pkg::S_DATA_W-1:0] s_tdata,   // value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // character
    output logic                          m_tlast    // last
);
    import sitoa_pkg::*;

    // conversion pipeline registers, stage 0 holds sign and magnitude
    logic                vld_reg [0:STAGE_N];
    logic                neg_reg [0:STAGE_N];
    logic [BCD_W-1:0]    bcd_reg [0:STAGE_N];
    logic [PAD_BITS-1:0] bin_reg [0:STAGE_N-1];

    logic [BCD_W-1:0]    bcd_next [1:STAGE_N];
    logic [PAD_BITS-1:0] bin_next [1:STAGE_N-1];

    // leading digit stage
    logic             lead_vld_reg;
    logic             lead_neg_reg;
    logic [BCD_W-1:0] lead_bcd_reg;
    logic [DIG_W-1:0] lead_top_reg;
    logic [DIG_W-1:0] lead_top_next;

    // serializer
    logic             ser_vld_reg;
    logic             ser_minus_reg;
    logic [BCD_W-1:0] ser_bcd_reg;
    logic [DIG_W-1:0] ser_idx_reg;

    logic [VALUE_BITS-1:0] raw;
    logic                  raw_neg;
    logic [VALUE_BITS-1:0] raw_mag;
    logic                  out_fire;
    logic                  ser_load;
    logic                  pipe_en;

    // magnitude in unsigned arithmetic so the most negative value is exact
    assign raw     = s_tdata[VALUE_BITS-1:0];
    assign raw_neg = raw[VALUE_BITS-1];
    assign raw_mag = raw_neg ? (~raw + 1'b1) : raw;

    // handshake and global pipeline advance
    assign out_fire = m_tvalid && m_tready;
    assign ser_load = !ser_vld_reg || (out_fire && m_tlast);
    assign pipe_en  = !lead_vld_reg || ser_load;
    assign s_tready = pipe_en;

    // shift-add-3 steps, STEP_BITS magnitude bits per stage
    always_comb begin
        logic [BCD_W-1:0]    t_bcd;
        logic [PAD_BITS-1:0] t_bin;
        for (int s = 0; s < STAGE_N; s++) begin
            t_bcd = bcd_reg[s];
            t_bin = bin_reg[s];
            for (int k = 0; k < STEP_BITS; k++) begin
                for (int d = 0; d < DIG_N; d++) begin
                    if (t_bcd[d*4 +: 4] >= 4'd5) begin
                        t_bcd[d*4 +: 4] = t_bcd[d*4 +: 4] + 4'd3;
                    end
                end
                {t_bcd, t_bin} = {t_bcd[BCD_W-2:0], t_bin, 1'b0};
            end
            bcd_next[s+1] = t_bcd;
            if (s < STAGE_N - 1) begin
                bin_next[s+1] = t_bin;
            end
        end
    end

    // highest nonzero digit, zero when all digits are zero
    always_comb begin
        lead_top_next = '0;
        for (int d = 0; d < DIG_N; d++) begin
            if (bcd_reg[STAGE_N][d*4 +: 4] != 4'd0) begin
                lead_top_next = DIG_W'(d);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= STAGE_N; s++) begin
                vld_reg[s] <= 1'b0;
            end
            lead_vld_reg <= 1'b0;
            ser_vld_reg  <= 1'b0;
        end else begin
            if (pipe_en) begin
                vld_reg[0] <= s_tvalid;
                for (int s = 1; s <= STAGE_N; s++) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
                lead_vld_reg <= vld_reg[STAGE_N];
            end
            if (ser_load) begin
                ser_vld_reg <= lead_vld_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            neg_reg[0] <= raw_neg;
            bcd_reg[0] <= '0;
            bin_reg[0] <= PAD_BITS'(raw_mag);
            for (int s = 1; s <= STAGE_N; s++) begin
                neg_reg[s] <= neg_reg[s-1];
                bcd_reg[s] <= bcd_next[s];
            end
            for (int s = 1; s < STAGE_N; s++) begin
                bin_reg[s] <= bin_next[s];
            end
            lead_neg_reg <= neg_reg[STAGE_N];
            lead_bcd_reg <= bcd_reg[STAGE_N];
            lead_top_reg <= lead_top_next;
        end
    end

    // serializer: minus sign first, then digits from the top one down
    always_ff @(posedge aclk) begin
        if (ser_load) begin
            ser_minus_reg <= lead_neg_reg;
            ser_bcd_reg   <= lead_bcd_reg;
            ser_idx_reg   <= lead_top_reg;
        end else if (out_fire) begin
            if (ser_minus_reg) begin
                ser_minus_reg <= 1'b0;
            end else begin
                ser_idx_reg <= ser_idx_reg - 1'b1;
            end
        end
    end

    // output character select
    assign m_tvalid = ser_vld_reg;
    assign m_tdata  = ser_minus_reg ? CHAR_MINUS
                                    : CHAR_ZERO + {4'd0, ser_bcd_reg[ser_idx_reg*4 +: 4]};
    assign m_tlast  = !ser_minus_reg && (ser_idx_reg == '0);

endmodule

FILE: tb/tb_signed_int_to_decimal_ascii_top.sv
// testbench for the signed integer to decimal ascii converter with a local predictor
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_top;
    import sitoa_pkg::*;

    localparam int RANDOM_ITEMS    = 196;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;

    // one expected output item: a character and its last mark
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tlast;

    logic [S_DATA_W-1:0] pending_values [$];
    text_char_t          expected_chars [$];

    int error_count     = 0;
    int values_sent     = 0;
    int negatives_sent  = 0;
    int chars_checked   = 0;
    int texts_done      = 0;
    int text_len        = 0;
    int longest_text    = 0;
    int idle_cycles     = 0;

    signed_int_to_decimal_ascii_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // decimal text of one signed value, appended to the expected characters
    function automatic void format_decimal(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [3:0]            digits [$];
        logic [3:0]            digit;
        // two's complement negate in unsigned bits covers the most negative value
        magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        do begin
            digits.push_front(4'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (value[VALUE_BITS-1]) begin
            expected_chars.push_back('{character: CHAR_MINUS, last: 1'b0});
        end
        while (digits.size() > 0) begin
            digit = digits.pop_front();
            expected_chars.push_back('{character: CHAR_ZERO + 8'(digit),
                                       last: (digits.size() == 0)});
        end
    endfunction

    // sender: bursts of items with random gaps, holds an item until accepted
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                format_decimal(s_tdata[VALUE_BITS-1:0]);
                values_sent++;
                if (s_tdata[VALUE_BITS-1]) negatives_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_values.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_values.pop_front();
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(30, 1);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        // half the time a short gap, otherwise none or a long one
                        case ($urandom_range(3, 0))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(20, 8);
                            default: gap_left = $urandom_range(5, 1);
                        endcase
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern in modes of random length, plus result checking
    int ready_mode = 0;
    int mode_left  = 0;

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end

            if (m_tvalid && m_tready) begin
                chars_checked++;
                text_len++;
                if (m_tlast) begin
                    texts_done++;
                    if (text_len > longest_text) longest_text = text_len;
                    text_len = 0;
                end
                if (expected_chars.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("unexpected item: char %0d last %0b", m_tdata, m_tlast);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.character || m_tlast !== want.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display({"mismatch at char %0d: expected char %0d last %0b, ",
                                      "got char %0d last %0b"},
                                     chars_checked, want.character, want.last,
                                     m_tdata, m_tlast);
                        end
                    end
                end
            end
        end

        if (mode_left == 0) begin
            ready_mode = $urandom_range(2, 0);
            mode_left  = $urandom_range(60, 10);
        end
        mode_left--;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(1, 0) == 1);
            default: m_tready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    // watchdog on a stream that stops moving
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned n_dig;
        int unsigned lo;
        int unsigned hi;
        logic [31:0] v;

        // extremes, digit-count boundaries, zero, most negative value
        pending_values = '{
            32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
            32'd100, -32'sd100, 32'd12345, -32'sd67890, 32'd999999999,
            32'd1000000000, -32'sd1000000000, 32'd2147483647, -32'sd2147483647,
            32'h8000_0000, 32'd2147483640, 32'd1073741824, 32'h5555_5555,
            32'haaaa_aaaa, 32'd7, -32'sd2000000000
        };

        // random part: mostly a chosen digit count with random sign, some raw words
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(9, 0) < 3) begin
                v = $urandom();
            end else begin
                n_dig = $urandom_range(10, 1);
                lo = 1;
                for (int k = 1; k < n_dig; k++) lo = lo * 10;
                hi = (n_dig == 10) ? 32'd2147483647 : lo * 10 - 1;
                if (n_dig == 1) lo = 0;
                v = $urandom_range(hi, lo);
                if ($urandom_range(1, 0)) v = -v;
            end
            pending_values.push_back(v);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_values.size() != 0 || s_tvalid || expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("converted %0d values (%0d negative) into %0d texts, %0d characters checked",
                 values_sent, negatives_sent, texts_done, chars_checked);
        $display("longest text %0d characters, %0d errors", longest_text, error_count);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
